// ===== sv/fixed_range_histogram_macros.svh =====
// Assertion macros for the fixed-range histogram block.
// Included by fixed_range_histogram.sv, which carries concurrent checks; needs nothing else.
`ifndef FIXED_RANGE_HISTOGRAM_MACROS_SVH
`define FIXED_RANGE_HISTOGRAM_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FRH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define FRH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/frh_pkg.sv =====
// Shared types, codes and helper functions for the fixed-range histogram.
// Used by frh_div and fixed_range_histogram; depends on nothing.
package frh_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int COUNT_BITS  = 32;
    localparam int BIN_IDX_W   = 10;
    localparam int BIN_CNT_W   = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Transaction actions
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Sample classes
    localparam logic [1:0] CLS_IN    = 2'd0;
    localparam logic [1:0] CLS_UNDER = 2'd1;
    localparam logic [1:0] CLS_OVER  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUMULATIVE = 2'd3;

    typedef struct packed {
        logic [1:0]                    action;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [BIN_IDX_W-1:0]          bin_index;
    } frh_in_t;

    typedef struct packed {
        logic [1:0]            sample_class;
        logic [BIN_IDX_W-1:0]  sample_bin;
        logic [COUNT_BITS-1:0] bin_value;
        logic [COUNT_BITS-1:0] underflow_total;
        logic [COUNT_BITS-1:0] overflow_total;
        logic [COUNT_BITS-1:0] in_range_total;
    } frh_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } frh_div_stat_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLASS,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_BUMP_RD,
        ST_BUMP_WR,
        ST_SUM,
        ST_SUM_END,
        ST_CLEAR,
        ST_DONE
    } frh_state_t;

    // Increment a count, holding at full scale
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS-1:0] r;
        r = (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
        return r;
    endfunction

    // Add two counts, holding at full scale
    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

endpackage

// ===== sv/frh_div.sv =====
// Restoring divider producing a short quotient, one bit per cycle.
// Depends on frh_pkg for the status struct; the upper dividend bits must be below the divisor.
module frh_div import frh_pkg::*; #(
    parameter int QW = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [32+QW-1:0]     dividend,
    input  logic [31:0]          divisor,
    output logic [QW-1:0]        quotient,
    output frh_div_stat_t        status
);

    localparam int CW = $clog2(QW + 1);

    logic [31:0]   rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [31:0]   div_reg, div_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [33:0]   diff;
    logic          fits;

    // Trial subtract of the divisor from the shifted partial remainder
    assign diff = {1'b0, rem_reg, quo_reg[QW-1]} - {2'b00, div_reg};
    assign fits = ~diff[33];

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend[32+QW-1:QW];
            quo_next  = dividend[QW-1:0];
            div_next  = divisor;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[31:0] : {rem_reg[30:0], quo_reg[QW-1]};
            quo_next = (quo_reg << 1) | QW'(fits);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== sv/fixed_range_histogram.sv =====
// Fixed-range histogram: sequencer, count memory and totals around the restoring divider.
// Depends on frh_pkg, frh_div and fixed_range_histogram_macros.svh.
//
// Samples are classed against range_low/range_high and in-range ones are binned as
// floor((x - low) * bins / (high - low)); reads return a bin count or a cumulative sum.
// One transaction is worked at a time. An in-range add multiplies, divides and then
// reads and writes back its bin; the divider retires one quotient bit per cycle. With
// equal range edges the multiply and divide are skipped and the sample lands in bin 0;
// a sample outside the range goes straight to the result. A cumulative read of bin i adds
// the underflow total and words 0 to i, one memory word per cycle through the single read
// port; a read past the bins in use or an unused action code goes straight to the result.
// A clear sweeps the count memory and zeroes the totals. s_ready rises again in the cycle
// the result appears. After reset the same clearing pass runs with s_ready low;
// configuration writes are taken at any time.
// A new transaction is accepted while the previous result still waits on m_ready.
`include "fixed_range_histogram_macros.svh"

module fixed_range_histogram import frh_pkg::*; #(
    parameter int MAX_BINS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  frh_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output frh_out_t              m_data
);

    localparam int AW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NB_W = $clog2(MAX_BINS + 1);
    localparam int PW   = 32 + NB_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);

    // Configuration
    logic signed [SAMPLE_BITS-1:0] low_reg, high_reg;
    logic [BIN_CNT_W-1:0]          bins_reg;
    logic                          cum_reg;

    // Sequencer and datapath
    frh_state_t            state_reg, state_next;
    frh_in_t               in_reg, in_next;
    logic [1:0]            cls_reg, cls_next;
    logic [BIN_IDX_W-1:0]  sbin_reg, sbin_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next;
    logic [COUNT_BITS-1:0] under_reg, under_next;
    logic [COUNT_BITS-1:0] over_reg, over_next;
    logic [COUNT_BITS-1:0] inr_reg, inr_next;
    logic [31:0]           off_reg, off_next;
    logic [31:0]           span_reg, span_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [NB_W-1:0]       k_reg, k_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic                  dvld_reg, dvld_next;
    frh_out_t              out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;

    logic [NB_W-1:0]       nb;
    logic                  accept;
    logic                  below, above;
    logic                  out_free;
    logic [AW-1:0]         sum_end;
    logic [32:0]           off_wide, span_wide;

    // Count memory
    logic [COUNT_BITS-1:0] mem [MAX_BINS];
    logic [COUNT_BITS-1:0] mem_rdata_reg;
    logic [AW-1:0]         mem_raddr, mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_we;

    // Divider
    logic                  div_start;
    logic [NB_W-1:0]       div_q;
    frh_div_stat_t         div_stat;

    frh_div #(.QW(NB_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .quotient (div_q),
        .status   (div_stat)
    );

    // Bins in use: zero means one, clamp to the memory depth
    always_comb begin
        if (bins_reg == '0) begin
            nb = NB_W'(1);
        end else if (int'(bins_reg) > MAX_BINS) begin
            nb = NB_W'(MAX_BINS);
        end else begin
            nb = NB_W'(bins_reg);
        end
    end

    assign accept    = s_valid && s_ready;
    assign below     = in_reg.sample < low_reg;
    assign above     = in_reg.sample > high_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign sum_end   = AW'(in_reg.bin_index);
    assign off_wide  = {in_reg.sample[SAMPLE_BITS-1], in_reg.sample}
                     - {low_reg[SAMPLE_BITS-1], low_reg};
    assign span_wide = {high_reg[SAMPLE_BITS-1], high_reg}
                     - {low_reg[SAMPLE_BITS-1], low_reg};

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= 32'sd65535;
            bins_reg <= BIN_CNT_W'(16);
            cum_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_RANGE_LOW:  low_reg  <= cfg_data[SAMPLE_BITS-1:0];
                CFG_RANGE_HIGH: high_reg <= cfg_data[SAMPLE_BITS-1:0];
                CFG_BIN_COUNT:  bins_reg <= cfg_data[BIN_CNT_W-1:0];
                CFG_CUMULATIVE: cum_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (ptr_reg == LAST_ADDR) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.action)
                        ACT_ADD:   state_next = ST_CLASS;
                        ACT_READ:  state_next = (int'(s_data.bin_index) < int'(nb)) ?
                                                ST_SUM : ST_DONE;
                        ACT_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLASS: begin
                if (below || above) begin
                    state_next = ST_DONE;
                end else if (span_wide[31:0] == '0) begin
                    state_next = ST_BUMP_RD;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:     state_next = ST_DIV_GO;
            ST_DIV_GO:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_stat.done) state_next = ST_BUMP_RD;
            end
            ST_BUMP_RD: state_next = ST_BUMP_WR;
            ST_BUMP_WR: state_next = ST_DONE;
            ST_SUM: begin
                if (ptr_reg == sum_end) state_next = ST_SUM_END;
            end
            ST_SUM_END: state_next = ST_DONE;
            ST_CLEAR: begin
                if (ptr_reg == LAST_ADDR) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control outputs: handshake, divider start, memory port
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = '0;
        mem_raddr = ptr_reg;
        unique case (state_reg)
            ST_IDLE:    s_ready = 1'b1;
            ST_DIV_GO:  div_start = 1'b1;
            ST_BUMP_RD: mem_raddr = AW'(k_reg);
            ST_BUMP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(k_reg);
                mem_wdata = sat_inc(mem_rdata_reg);
            end
            ST_INIT, ST_CLEAR: mem_we = 1'b1;
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        in_next      = in_reg;
        cls_next     = cls_reg;
        sbin_next    = sbin_reg;
        acc_next     = acc_reg;
        under_next   = under_reg;
        over_next    = over_reg;
        inr_next     = inr_reg;
        off_next     = off_reg;
        span_next    = span_reg;
        prod_next    = prod_reg;
        k_next       = k_reg;
        ptr_next     = ptr_reg;
        dvld_next    = dvld_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_INIT: ptr_next = ptr_reg + 1'b1;
            ST_IDLE: begin
                if (accept) begin
                    in_next   = s_data;
                    cls_next  = CLS_IN;
                    sbin_next = '0;
                    k_next    = '0;
                    dvld_next = 1'b0;
                    // Seed a cumulative sum with underflow only for a bin in use
                    acc_next  = (s_data.action == ACT_READ && cum_reg &&
                                 int'(s_data.bin_index) < int'(nb)) ? under_reg : '0;
                    ptr_next  = (s_data.action == ACT_READ && !cum_reg) ?
                                AW'(s_data.bin_index) : '0;
                end
            end
            ST_CLASS: begin
                off_next  = off_wide[31:0];
                span_next = span_wide[31:0];
                if (below) begin
                    cls_next   = CLS_UNDER;
                    under_next = sat_inc(under_reg);
                end else if (above) begin
                    cls_next  = CLS_OVER;
                    over_next = sat_inc(over_reg);
                end
            end
            ST_MUL: prod_next = PW'(off_reg) * PW'(nb);
            ST_DIV: begin
                if (div_stat.done) begin
                    k_next = (div_q >= nb) ? nb - 1'b1 : div_q;
                end
            end
            ST_BUMP_WR: begin
                inr_next  = sat_inc(inr_reg);
                sbin_next = BIN_IDX_W'(k_reg);
            end
            ST_SUM: begin
                dvld_next = 1'b1;
                if (dvld_reg) acc_next = sat_add(acc_reg, mem_rdata_reg);
                if (ptr_reg != sum_end) ptr_next = ptr_reg + 1'b1;
            end
            ST_SUM_END: acc_next = sat_add(acc_reg, mem_rdata_reg);
            ST_CLEAR: begin
                ptr_next   = ptr_reg + 1'b1;
                under_next = '0;
                over_next  = '0;
                inr_next   = '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_next.sample_class    = cls_reg;
                    out_next.sample_bin      = sbin_reg;
                    out_next.bin_value       = acc_reg;
                    out_next.underflow_total = under_reg;
                    out_next.overflow_total  = over_reg;
                    out_next.in_range_total  = inr_reg;
                    m_valid_next             = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            ptr_reg     <= '0;
            dvld_reg    <= 1'b0;
            under_reg   <= '0;
            over_reg    <= '0;
            inr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            dvld_reg    <= dvld_next;
            under_reg   <= under_next;
            over_reg    <= over_next;
            inr_reg     <= inr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_reg   <= in_next;
        cls_reg  <= cls_next;
        sbin_reg <= sbin_next;
        acc_reg  <= acc_next;
        off_reg  <= off_next;
        span_reg <= span_next;
        prod_reg <= prod_next;
        k_reg    <= k_next;
        out_reg  <= out_next;
    end

    // Count memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Checks on the sequencer
    `FRH_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept,
        state_reg != ST_IDLE, "accepted transaction did not start work")
    `FRH_ASSERT_SAME(a_div_done_in_wait, aclk, aresetn, div_stat.done,
        state_reg == ST_DIV, "divider finished outside its wait state")
    `FRH_ASSERT_SAME(a_no_accept_in_sweep, aclk, aresetn,
        state_reg == ST_INIT || state_reg == ST_CLEAR, !s_ready,
        "input taken during clearing pass")
    `FRH_ASSERT_SAME(a_class_code, aclk, aresetn, m_valid,
        m_data.sample_class <= CLS_OVER, "result class code out of range")
    `FRH_ASSERT_SAME(a_bin_below_use, aclk, aresetn, state_reg == ST_BUMP_RD,
        k_reg < nb, "bin index beyond bins in use")

endmodule

// ===== tb/sv/histogram_checker.sv =====
// Checker for the fixed-range histogram: tracks settings, predicts every result, compares.
// Depends on frh_pkg for the transaction types, action codes and register indexes.
module histogram_checker
    import frh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  frh_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  frh_out_t              m_data,
    output int unsigned           outstanding,
    output int unsigned           mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BIN_SLOTS = 1024;
    localparam longint unsigned COUNT_FULL = (64'd1 << COUNT_BITS) - 1;

    // Model copy of the count store and the settings
    logic [COUNT_BITS-1:0]   bin_tally [BIN_SLOTS];
    logic [COUNT_BITS-1:0]   under_tally;
    logic [COUNT_BITS-1:0]   over_tally;
    logic [COUNT_BITS-1:0]   inside_tally;
    logic signed [31:0]      range_floor;
    logic signed [31:0]      range_ceiling;
    logic [BIN_CNT_W-1:0]    bin_limit;
    logic                    cumulative_mode;

    frh_out_t    predicted_outcomes [$];
    frh_out_t    awaited;
    int unsigned fault_count = 0;
    int unsigned results_seen = 0;

    assign mismatches = fault_count;

    function automatic logic [COUNT_BITS-1:0] bumped(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic void wipe_counts();
        foreach (bin_tally[i]) bin_tally[i] = '0;
        under_tally  = '0;
        over_tally   = '0;
        inside_tally = '0;
    endfunction

    // Update the model for one transaction and return the result it must produce
    function automatic frh_out_t tally_request(input frh_in_t req);
        frh_out_t          res;
        longint            value;
        longint            floor_v;
        longint            ceil_v;
        longint unsigned   offset;
        longint unsigned   width;
        longint unsigned   slot;
        longint unsigned   total;
        int unsigned       used;
        res = '0;
        used = (bin_limit == 0) ? 1 : ((bin_limit > BIN_SLOTS) ? BIN_SLOTS : bin_limit);
        case (req.action)
            ACT_ADD: begin
                value   = longint'($signed(req.sample));
                floor_v = longint'(range_floor);
                ceil_v  = longint'(range_ceiling);
                if (value < floor_v) begin
                    res.sample_class = CLS_UNDER;
                    under_tally = bumped(under_tally);
                end else if (value > ceil_v) begin
                    res.sample_class = CLS_OVER;
                    over_tally = bumped(over_tally);
                end else begin
                    slot = 0;
                    // Exact floor of offset * bins / span; the top edge lands in the last bin
                    if (ceil_v != floor_v) begin
                        offset = longint'(value - floor_v);
                        width  = longint'(ceil_v - floor_v);
                        slot   = (offset * used) / width;
                        if (slot >= used) slot = used - 1;
                    end
                    res.sample_class = CLS_IN;
                    res.sample_bin   = slot[BIN_IDX_W-1:0];
                    bin_tally[slot]  = bumped(bin_tally[slot]);
                    inside_tally     = bumped(inside_tally);
                end
            end
            ACT_READ: begin
                if (req.bin_index < used) begin
                    if (cumulative_mode) begin
                        total = under_tally;
                        for (int i = 0; i <= req.bin_index; i++) begin
                            total += bin_tally[i];
                            if (total > COUNT_FULL) total = COUNT_FULL;
                        end
                        res.bin_value = total[COUNT_BITS-1:0];
                    end else begin
                        res.bin_value = bin_tally[req.bin_index];
                    end
                end
            end
            ACT_CLEAR: wipe_counts();
            default: ;
        endcase
        res.underflow_total = under_tally;
        res.overflow_total  = over_tally;
        res.in_range_total  = inside_tally;
        return res;
    endfunction

    task automatic flag(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) flag($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    // Retire results against the oldest prediction, then queue the new transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            wipe_counts();
            range_floor     = 32'sd0;
            range_ceiling   = 32'sd65535;
            bin_limit       = 11'd16;
            cumulative_mode = 1'b0;
            predicted_outcomes.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RANGE_LOW:  range_floor     = cfg_data;
                    CFG_RANGE_HIGH: range_ceiling   = cfg_data;
                    CFG_BIN_COUNT:  bin_limit       = cfg_data[BIN_CNT_W-1:0];
                    CFG_CUMULATIVE: cumulative_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (predicted_outcomes.size() == 0) begin
                    flag("result arrived with no transaction waiting");
                end else begin
                    awaited = predicted_outcomes.pop_front();
                    compare_field("sample_class", awaited.sample_class, m_data.sample_class);
                    compare_field("sample_bin", awaited.sample_bin, m_data.sample_bin);
                    compare_field("bin_value", awaited.bin_value, m_data.bin_value);
                    compare_field("underflow_total", awaited.underflow_total,
                                  m_data.underflow_total);
                    compare_field("overflow_total", awaited.overflow_total,
                                  m_data.overflow_total);
                    compare_field("in_range_total", awaited.in_range_total,
                                  m_data.in_range_total);
                end
            end
            if (s_valid && s_ready) predicted_outcomes.push_back(tally_request(s_data));
            outstanding <= predicted_outcomes.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the fixed-range histogram testbench: clock, reset, stimulus, stalls and verdict.
// Depends on frh_pkg, fixed_range_histogram and histogram_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import frh_pkg::*;

    // Longest correct quiet spell is a clear or a full cumulative read over the whole count
    // memory plus a receiver stall; allow many times that.
    localparam int unsigned STALL_LIMIT = 20000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    frh_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    frh_out_t              m_data;

    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;

    // Settings as last written, used only to shape the stimulus
    longint      cur_low = 0;
    longint      cur_high = 65535;
    int unsigned cur_bins = 16;

    fixed_range_histogram DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    histogram_checker tally_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result channel: free-flowing, light, heavy and long-block stretches
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 9) < 7);
            2: m_ready <= ($urandom_range(0, 9) < 2);
            default: m_ready <= ((stall_left % 40) >= 30);
        endcase
    end

    // Abort when no transaction moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic frh_in_t request(input logic [1:0] act, input logic [31:0] value,
                                        input logic [BIN_IDX_W-1:0] idx);
        frh_in_t req;
        req.action    = act;
        req.sample    = value;
        req.bin_index = idx;
        return req;
    endfunction

    // Mostly adds and reads; samples favor the range and its edges
    function automatic frh_in_t random_request();
        frh_in_t         req;
        longint          edge_v;
        longint unsigned width;
        longint unsigned draw;
        int unsigned     pick;
        pick = $urandom_range(0, 99);
        req.action = (pick < 62) ? ACT_ADD : (pick < 94) ? ACT_READ :
                     (pick < 97) ? ACT_NONE : ACT_CLEAR;
        req.sample = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            case ($urandom_range(0, 5))
                0: edge_v = cur_low;
                1: edge_v = cur_high;
                2: edge_v = cur_low - 1;
                3: edge_v = cur_high + 1;
                4: edge_v = cur_low + 1;
                default: edge_v = cur_high - 1;
            endcase
            req.sample = 32'(edge_v);
        end else if (pick < 75 && cur_low <= cur_high) begin
            width = longint'(cur_high - cur_low) + 1;
            draw  = {$urandom, $urandom};
            req.sample = 32'(cur_low + longint'(draw % width));
        end
        if ($urandom_range(0, 4) != 0) begin
            req.bin_index = BIN_IDX_W'($urandom_range(0, cur_bins - 1));
        end else begin
            req.bin_index = BIN_IDX_W'($urandom);
        end
        return req;
    endfunction

    // Hold the transaction until it is accepted
    task automatic send_request(input frh_in_t req);
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Drop valid and wait for every predicted result, then a quiet pause
    task automatic drain_results(input int unsigned tail);
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (tail) @(posedge aclk);
    endtask

    // Write all four registers; unused upper data bits carry noise
    task automatic apply_setup(input logic signed [31:0] lo, input logic signed [31:0] hi,
                               input logic [BIN_CNT_W-1:0] count, input logic cum);
        write_register(CFG_RANGE_LOW, lo);
        write_register(CFG_RANGE_HIGH, hi);
        write_register(CFG_BIN_COUNT, {21'($urandom), count});
        write_register(CFG_CUMULATIVE, {31'($urandom), cum});
        cfg_valid <= 1'b0;
        cur_low  = longint'(lo);
        cur_high = longint'(hi);
        cur_bins = (count == 0) ? 1 : ((count > 1024) ? 1024 : count);
    endtask

    // Send in bursts of random length separated by random gaps
    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_request(random_request());
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0 && sent < count) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin
        logic signed [31:0] lo_pick;
        logic signed [31:0] hi_pick;
        logic signed [31:0] swap_tmp;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset settings, range 0..65535 in 16 bins
        send_request(request(ACT_ADD, 32'd0, 10'd0));
        send_request(request(ACT_ADD, 32'd65535, 10'd0));
        send_request(request(ACT_ADD, 32'd4095, 10'd0));
        send_request(request(ACT_ADD, 32'd4096, 10'd0));
        send_request(request(ACT_ADD, 32'd32768, 10'd1023));
        send_request(request(ACT_ADD, 32'hFFFF_FFFF, 10'd0));
        send_request(request(ACT_ADD, 32'd65536, 10'd0));
        send_request(request(ACT_ADD, 32'h8000_0000, 10'd0));
        send_request(request(ACT_ADD, 32'h7FFF_FFFF, 10'd0));
        send_request(request(ACT_READ, 32'd0, 10'd0));
        send_request(request(ACT_READ, 32'd0, 10'd15));
        send_request(request(ACT_READ, 32'hFFFF_FFFF, 10'd16));
        send_request(request(ACT_READ, 32'd0, 10'd1023));
        send_request(request(ACT_NONE, 32'hA5A5_5A5A, 10'd341));
        send_request(request(ACT_READ, 32'd0, 10'd1));
        send_request(request(ACT_CLEAR, 32'd0, 10'd0));
        send_request(request(ACT_READ, 32'd0, 10'd15));
        send_request(request(ACT_ADD, 32'd65535, 10'd0));
        send_request(request(ACT_READ, 32'd0, 10'd15));

        // Random phases, each under its own settings
        for (int phase = 0; phase < 9; phase++) begin
            drain_results(40);
            lo_pick = $urandom;
            hi_pick = $urandom;
            if (lo_pick > hi_pick) begin
                swap_tmp = lo_pick;
                lo_pick  = hi_pick;
                hi_pick  = swap_tmp;
            end
            case (phase)
                0: apply_setup(-32'sd1000, 32'sd1000, 11'd7, 1'b1);
                1: apply_setup(32'sh8000_0000, 32'sh7FFF_FFFF, 11'd1024, 1'b0);
                2: apply_setup(32'sh8000_0000, 32'sh7FFF_FFFF, 11'd1024, 1'b1);
                // equal edges, zero bins
                3: apply_setup(32'sd100, 32'sd100, 11'd0, 1'b1);
                // low above high: nothing in range
                4: apply_setup(32'sd500, -32'sd500, 11'd5, 1'b0);
                // bin count above the store size
                5: apply_setup(lo_pick, hi_pick, 11'd2047, 1'b1);
                6: apply_setup(32'sd10, 32'sd13, 11'd1024, 1'b1);
                7: apply_setup(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 11'd1, 1'b0);
                default: apply_setup(lo_pick, hi_pick, 11'($urandom_range(1, 1024)),
                                     1'($urandom_range(0, 1)));
            endcase
            run_random(135);
        end

        drain_results(1100);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
